// ===== rtl/mtes_pkg.sv =====
`timescale 1ns / 1ps

package mtes_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int LIMIT_BITS         = 16;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd4096;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_TAG    = 2'd1;
    localparam logic [1:0] MODE_ENTITY = 2'd2;

    localparam logic [7:0] CHAR_TAG_OPEN    = 8'h3C;
    localparam logic [7:0] CHAR_TAG_CLOSE   = 8'h3E;
    localparam logic [7:0] CHAR_AMPERSAND   = 8'h26;
    localparam logic [7:0] CHAR_SEMICOLON   = 8'h3B;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] CHAR_QUOTE       = 8'h22;

    localparam logic [31:0] NAME_NBSP = 32'h6E62_7370;
    localparam logic [31:0] NAME_QT   = 32'h0000_7174;
    localparam logic [31:0] NAME_LT   = 32'h0000_6C74;
    localparam logic [31:0] NAME_GT   = 32'h0000_6774;

    localparam logic [2:0] NAME_LEN_FULL = 3'd4;
    localparam logic [2:0] NAME_LEN_PAIR = 3'd2;
    localparam logic [2:0] NAME_LEN_LONG = 3'd5;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       char_valid;
        logic       finished;
        logic       truncated;
    } t_result;

endpackage

// ===== rtl/markup_tag_entity_stripper_core.sv =====
`timescale 1ns / 1ps
// Markup tag stripper and entity decoder.
// The input channel (i_valid, o_ready) takes one source byte per request, with
// i_end_of_text set on the last byte of a string. Tags are dropped, the
// entities nbsp, qt, lt and gt are decoded and other entities are dropped.
// The output channel (o_valid, i_ready) gives zero or one result per byte:
// an emitted character, the first refusal at the output limit, or the
// finishing result for the last byte of a string.
// The configuration channel (i_cfg_valid, o_cfg_ready) writes the output
// limit; it is always ready and the new limit applies to the next byte.
// The result for a byte is computed combinationally and registered in the output register, and
// one byte is accepted every cycle while the receiver keeps up: the parser
// state update and the limit compare sit between the parse state registers
// and the output register.
// When the receiver stalls, one further result is held in a skid register
// and o_ready then falls until the output register drains.
// Synchronous reset empties the output, returns the parser to plain text with
// a zero count and sets the output limit to 4096.
module markup_tag_entity_stripper_core #(
    parameter int COUNT_BITS = mtes_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_end_of_text,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_char_valid,
    output logic                            o_finished,
    output logic                            o_truncated,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mtes_pkg::LIMIT_BITS-1:0] i_cfg_output_limit
);
    import mtes_pkg::*;

    logic [LIMIT_BITS-1:0] r_output_limit;
    logic                  accept;
    logic                  push;
    t_result               parse_result;
    t_result               out_result;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_output_limit <= i_cfg_output_limit;
        end
    end

    mtes_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_output_limit (r_output_limit),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_text  (i_end_of_text),
        .o_push         (push),
        .o_result       (parse_result)
    );

    mtes_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (parse_result),
        .o_space  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_out_byte   = out_result.out_byte;
    assign o_char_valid = out_result.char_valid;
    assign o_finished   = out_result.finished;
    assign o_truncated  = out_result.truncated;

endmodule

// ===== rtl/mtes_parser.sv =====
`timescale 1ns / 1ps

module mtes_parser #(
    parameter int COUNT_BITS = mtes_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mtes_pkg::LIMIT_BITS-1:0] i_output_limit,
    input  logic                          i_accept,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_end_of_text,
    output logic                          o_push,
    output mtes_pkg::t_result             o_result
);
    import mtes_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    logic [1:0]            r_mode,   n_mode;
    logic [31:0]           r_name,   n_name;
    logic [2:0]            r_len,    n_len;
    logic [COUNT_BITS-1:0] r_count,  n_count;
    logic                  r_halted, n_halted;

    logic [LIMIT_BITS-1:0] cap_limit;
    logic [CMP_BITS-1:0]   cap_cmp;
    logic [CMP_BITS-1:0]   count_cmp;
    logic                  at_cap;
    logic                  emit;
    logic                  trunc_event;
    logic [7:0]            ch;

    always_comb begin
        cap_limit = (i_output_limit == '0) ? '0 : i_output_limit - 1'b1;
        cap_cmp   = CMP_BITS'(cap_limit);
        count_cmp = CMP_BITS'(r_count);
        at_cap    = (count_cmp >= cap_cmp) || (r_count == '1);
    end

    always_comb begin
        n_mode      = r_mode;
        n_name      = r_name;
        n_len       = r_len;
        n_count     = r_count;
        n_halted    = r_halted;
        emit        = 1'b0;
        trunc_event = 1'b0;
        ch          = 8'h00;

        if (!r_halted) begin
            case (r_mode)
                MODE_TAG: begin
                    if (i_in_byte == CHAR_TAG_CLOSE) begin
                        n_mode = MODE_PLAIN;
                    end
                end
                MODE_ENTITY: begin
                    if (i_in_byte == CHAR_SEMICOLON) begin
                        n_mode = MODE_PLAIN;
                        if (r_len == NAME_LEN_FULL && r_name == NAME_NBSP) begin
                            ch   = CHAR_SPACE;
                            emit = 1'b1;
                        end else if (r_len == NAME_LEN_PAIR) begin
                            if (r_name == NAME_QT) begin
                                ch   = CHAR_QUOTE;
                                emit = 1'b1;
                            end else if (r_name == NAME_LT) begin
                                ch   = CHAR_TAG_OPEN;
                                emit = 1'b1;
                            end else if (r_name == NAME_GT) begin
                                ch   = CHAR_TAG_CLOSE;
                                emit = 1'b1;
                            end
                        end
                    end else if (r_len < NAME_LEN_FULL) begin
                        n_name = {r_name[23:0], i_in_byte};
                        n_len  = r_len + 1'b1;
                    end else begin
                        n_len = NAME_LEN_LONG;
                    end
                end
                default: begin
                    n_mode = MODE_PLAIN;
                    if (i_in_byte == CHAR_TAG_OPEN) begin
                        n_mode = MODE_TAG;
                    end else if (i_in_byte == CHAR_AMPERSAND) begin
                        n_mode = MODE_ENTITY;
                        n_name = '0;
                        n_len  = '0;
                    end else begin
                        ch   = i_in_byte;
                        emit = 1'b1;
                    end
                end
            endcase

            if (emit) begin
                if (at_cap) begin
                    emit        = 1'b0;
                    ch          = 8'h00;
                    n_halted    = 1'b1;
                    trunc_event = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
        end

        o_push              = i_accept && (emit || trunc_event || i_end_of_text);
        o_result.out_byte   = ch;
        o_result.char_valid = emit;
        o_result.finished   = i_end_of_text;
        o_result.truncated  = n_halted;

        if (i_end_of_text) begin
            n_mode   = MODE_PLAIN;
            n_name   = '0;
            n_len    = '0;
            n_count  = '0;
            n_halted = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_name   <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_halted <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_name   <= n_name;
            r_len    <= n_len;
            r_count  <= n_count;
            r_halted <= n_halted;
        end
    end

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= NAME_LEN_LONG)
        else $error("Entity name length out of range.");

    a_string_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_text |=> r_mode == MODE_PLAIN && r_count == '0 && !r_halted)
        else $error("State not cleared after the last byte of a string.");

    a_char_not_truncated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.char_valid |-> !o_result.truncated)
        else $error("Character emitted while output is truncated.");

    a_halted_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted && !(i_accept && i_end_of_text) |=> r_halted && $stable(r_count))
        else $error("Halted state released before the end of the string.");
`endif

endmodule

// ===== rtl/mtes_outbuf.sv =====
`timescale 1ns / 1ps

module mtes_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtes_pkg::t_result i_result,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output mtes_pkg::t_result o_result
);
    import mtes_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop      = r_out_valid && i_ready;
    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import mtes_pkg::*;

    localparam int CNT_MAX       = (1 << COUNT_BITS_DEFAULT) - 1;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 128;
    localparam int SETTLE_CYCLES = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_in_byte = 8'h00;
    logic                  i_end_of_text = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_char_valid;
    logic                  o_finished;
    logic                  o_truncated;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [LIMIT_BITS-1:0] i_cfg_output_limit = LIMIT_RESET;

    t_result seen_result;
    assign seen_result = {o_out_byte, o_char_valid, o_finished, o_truncated};

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic [7:0] pending_text[$];

    markup_tag_entity_stripper_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_in_byte          (i_in_byte),
        .i_end_of_text      (i_end_of_text),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_byte         (o_out_byte),
        .o_char_valid       (o_char_valid),
        .o_finished         (o_finished),
        .o_truncated        (o_truncated),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_output_limit (i_cfg_output_limit)
    );

    class strip_scoreboard;
        logic [LIMIT_BITS-1:0] limit;
        logic [1:0]            mode;
        logic [31:0]           name;
        logic [2:0]            name_len;
        int                    count;
        bit                    halted;
        t_result               expected_chars[$];
        int                    failures;

        function new();
            limit = LIMIT_RESET;
            failures = 0;
            clear_string();
        endfunction

        function void clear_string();
            mode = MODE_PLAIN;
            name = '0;
            name_len = '0;
            count = 0;
            halted = 1'b0;
        endfunction

        function void set_limit(logic [LIMIT_BITS-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // Returns 1 when the byte was parsed rather than ignored after a halt.
        function bit take_byte(logic [7:0] b, bit last);
            bit         emit;
            bit         cut;
            bit         live;
            logic [7:0] ch;
            int         cap;
            t_result    r;
            emit = 1'b0;
            cut = 1'b0;
            ch = 8'h00;
            live = !halted;
            if (!halted) begin
                case (mode)
                    MODE_TAG: begin
                        if (b == CHAR_TAG_CLOSE) mode = MODE_PLAIN;
                    end
                    MODE_ENTITY: begin
                        if (b == CHAR_SEMICOLON) begin
                            mode = MODE_PLAIN;
                            if (name_len == NAME_LEN_FULL && name == NAME_NBSP) begin
                                ch = CHAR_SPACE;
                                emit = 1'b1;
                            end else if (name_len == NAME_LEN_PAIR) begin
                                if (name == NAME_QT) begin
                                    ch = CHAR_QUOTE;
                                    emit = 1'b1;
                                end else if (name == NAME_LT) begin
                                    ch = CHAR_TAG_OPEN;
                                    emit = 1'b1;
                                end else if (name == NAME_GT) begin
                                    ch = CHAR_TAG_CLOSE;
                                    emit = 1'b1;
                                end
                            end
                        end else if (name_len < NAME_LEN_FULL) begin
                            name = {name[23:0], b};
                            name_len++;
                        end else begin
                            name_len = NAME_LEN_LONG;
                        end
                    end
                    default: begin
                        mode = MODE_PLAIN;
                        if (b == CHAR_TAG_OPEN) begin
                            mode = MODE_TAG;
                        end else if (b == CHAR_AMPERSAND) begin
                            mode = MODE_ENTITY;
                            name = '0;
                            name_len = '0;
                        end else begin
                            ch = b;
                            emit = 1'b1;
                        end
                    end
                endcase
                if (emit) begin
                    cap = (limit == 0) ? 0 : int'(limit) - 1;
                    if (cap > CNT_MAX) cap = CNT_MAX;
                    if (count >= cap) begin
                        emit = 1'b0;
                        ch = 8'h00;
                        halted = 1'b1;
                        cut = 1'b1;
                    end else begin
                        count++;
                    end
                end
            end
            if (emit || cut || last) begin
                r.out_byte = emit ? ch : 8'h00;
                r.char_valid = emit;
                r.finished = last;
                r.truncated = halted;
                expected_chars.push_back(r);
            end
            if (last) clear_string();
            return live;
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected result: byte %02h valid %b finished %b truncated %b",
                                 got.out_byte, got.char_valid, got.finished, got.truncated));
                return;
            end
            want = expected_chars.pop_front();
            if (got !== want) begin
                report($sformatf({"result differs: expected byte %02h valid %b finished %b ",
                                  "truncated %b, got byte %02h valid %b finished %b truncated %b"},
                                 want.out_byte, want.char_valid, want.finished, want.truncated,
                                 got.out_byte, got.char_valid, got.finished, got.truncated));
            end
        endfunction
    endclass

    strip_scoreboard board = new();

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit roll(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    always @(negedge i_clk) begin
        i_ready = !roll(recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.match_result(seen_result);
    end

    function automatic void push_name(logic [31:0] nm, int n);
        for (int i = n - 1; i >= 0; i--) pending_text.push_back(nm[i*8 +: 8]);
    endfunction

    function automatic void push_entity();
        int kind;
        int n;
        kind = $urandom_range(7, 0);
        pending_text.push_back(CHAR_AMPERSAND);
        case (kind)
            0: push_name(NAME_NBSP, 4);
            1: push_name(NAME_QT, 2);
            2: push_name(NAME_LT, 2);
            3: push_name(NAME_GT, 2);
            4: push_name(NAME_LT ^ 32'h0000_2020, 2);
            5: begin
                n = $urandom_range(6, 1);
                repeat (n) pending_text.push_back(8'($urandom_range(8'h7A, 8'h61)));
            end
            6: begin
                n = $urandom_range(6, 0);
                repeat (n) pending_text.push_back(8'($urandom_range(255, 0)));
            end
            default: begin
                if (roll(50)) push_name(NAME_NBSP >> 8, 3);
                else push_name({NAME_NBSP[23:0], 8'h78}, 4);
            end
        endcase
        if (roll(90)) pending_text.push_back(CHAR_SEMICOLON);
    endfunction

    function automatic void compose_string();
        int tokens;
        int pick;
        int n;
        tokens = roll(15) ? $urandom_range(40, 12) : $urandom_range(10, 1);
        repeat (tokens) begin
            pick = $urandom_range(99, 0);
            if (pick < 40) begin
                if (roll(30)) pending_text.push_back(8'($urandom_range(255, 0)));
                else pending_text.push_back(8'($urandom_range(126, 32)));
            end else if (pick < 55) begin
                pending_text.push_back(CHAR_TAG_OPEN);
                n = $urandom_range(5, 0);
                repeat (n) pending_text.push_back(8'($urandom_range(8'h7A, 8'h26)));
                if (roll(90)) pending_text.push_back(CHAR_TAG_CLOSE);
            end else if (pick < 85) begin
                push_entity();
            end else begin
                pending_text.push_back(8'($urandom_range(255, 0)));
            end
        end
        if (roll(10)) begin
            pending_text.push_back(roll(50) ? CHAR_TAG_OPEN : CHAR_AMPERSAND);
            pending_text.push_back(NAME_LT[15:8]);
        end
    endfunction

    // Each task starts and ends at a falling edge.
    task automatic push_byte(logic [7:0] b, bit last, output bit live);
        while (roll(send_idle_pct)) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_in_byte = b;
        i_end_of_text = last;
        do @(posedge i_clk); while (!o_ready);
        live = board.take_byte(b, last);
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        bit live;
        for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1, live);
    endtask

    task automatic write_limit(logic [LIMIT_BITS-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_output_limit = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_limit(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stops sending, waits until the store of expected results empties and then
    // lets the output settle before the next phase.
    task automatic drain();
        i_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [LIMIT_BITS-1:0] limits[PHASE_COUNT];
        logic [7:0]            b;
        bit                    last;
        bit                    live;
        int                    done;
        limits = '{16'd4096, 16'd0, 16'd1, 16'd2, 16'd6, 16'd65535, 16'd3, 16'd15};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_limit(16'hFFFF);
        send_text("<&>&nbsp;");
        send_text("&gt;&x<qtz;");
        push_byte(8'h00, 1'b0, live);
        push_byte(8'hFF, 1'b0, live);
        send_text("&lt");
        send_text("&qt;<b");
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain();
            write_limit(limits[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            done = 0;
            while (done < PHASE_ITEMS) begin
                if (pending_text.size() == 0) compose_string();
                b = pending_text.pop_front();
                last = (pending_text.size() == 0);
                push_byte(b, last, live);
                done++;
            end
        end
        i_valid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("markup_tag_entity_stripper_core: match");
        end else begin
            $display("markup_tag_entity_stripper_core: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("markup_tag_entity_stripper_core: mismatch");
        $finish;
    end

endmodule
